@@ design/sfla_pkg.sv @@
// shared types, codes and defaults for the slot free-list allocator
package sfla_pkg;

    localparam int SLOTS_DEFAULT = 64;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_USED = 2'd2
    } status_t;

    typedef struct packed
    {
        logic load;
        logic exec;
    } cmd_t;

endpackage

@@ design/sfla_ram.sv @@
// generic single write port ram with registered read
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sfla_ctrl.sv @@
// request sequencer for the slot free-list allocator
module sfla_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output sfla_pkg::cmd_t cmd
);

    import sfla_pkg::*;

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = busy_reg;
    assign cmd.load = start && !busy_reg;
    assign cmd.exec = (state_reg == S_EXEC);

`ifndef SYNTHESIS
    a_exec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("request not executed after accept");
    a_no_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !cmd.load)
        else $error("request accepted while executing");
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec)
        else $error("execute lasted more than one cycle");
`endif

endmodule

@@ design/sfla_dp.sv @@
// free stack, used marks, counters and result registers
module sfla_dp #(
    parameter int SLOTS = sfla_pkg::SLOTS_DEFAULT,
    localparam int IW = $clog2(SLOTS),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  sfla_pkg::cmd_t cmd,
    input  logic           operation,
    input  logic [IW-1:0]  slot_index,
    output logic           done,
    output logic [1:0]     status,
    output logic [IW-1:0]  granted_slot,
    output logic [CW-1:0]  slots_in_use
);

    import sfla_pkg::*;

    logic             op_reg;
    logic [IW-1:0]    idx_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    low_reg, low_next;
    logic             done_reg;
    status_t          status_reg, status_next;
    logic [IW-1:0]    granted_reg, granted_next;

    logic [CW-1:0]    height;
    logic [CW-1:0]    height_m1;
    logic [IW-1:0]    top_pos;
    logic [IW-1:0]    ram_rdata;
    logic [IW-1:0]    top_slot;
    logic [0:0]       mark_rdata;
    logic             idx_used;
    logic             idx_ok;
    logic             alloc_ok;
    logic             ram_we;
    logic             mark_we;
    logic [IW-1:0]    mark_waddr;
    logic [0:0]       mark_wdata;

    assign height    = CW'(SLOTS) - count_reg;
    assign height_m1 = height - CW'(1);
    assign top_pos   = height_m1[IW-1:0];

    // positions below the low-water mark were never written, so they read as their own index
    assign top_slot = (CW'(top_pos) < low_reg) ? top_pos : ram_rdata;
    // slots below the low-water mark were never granted, so they are unused
    assign idx_used = (CW'(idx_reg) >= low_reg) && mark_rdata[0];
    assign idx_ok   = (CW'(idx_reg) < CW'(SLOTS)) && idx_used
                      && (count_reg != '0);
    assign alloc_ok = (op_t'(op_reg) == OP_ALLOC) && (count_reg != CW'(SLOTS));
    assign ram_we   = cmd.exec && (op_t'(op_reg) == OP_FREE) && idx_ok;
    assign mark_we  = (cmd.exec && alloc_ok) || ram_we;

    assign mark_waddr = (op_t'(op_reg) == OP_ALLOC) ? top_slot : idx_reg;
    assign mark_wdata = (op_t'(op_reg) == OP_ALLOC) ? 1'b1 : 1'b0;

    sfla_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (height[IW-1:0]),
        .wdata (idx_reg),
        .re    (cmd.load),
        .raddr (top_pos),
        .rdata (ram_rdata)
    );

    sfla_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_marks (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.load),
        .raddr (slot_index),
        .rdata (mark_rdata)
    );

    always_comb
    begin
        count_next   = count_reg;
        low_next     = low_reg;
        status_next  = ST_DONE;
        granted_next = '0;
        if (op_t'(op_reg) == OP_ALLOC)
        begin
            if (count_reg == CW'(SLOTS))
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                granted_next = top_slot;
                count_next   = count_reg + CW'(1);
                if (CW'(top_pos) < low_reg)
                begin
                    low_next = CW'(top_pos);
                end
            end
        end
        else
        begin
            if (!idx_ok)
            begin
                status_next = ST_NOT_USED;
            end
            else
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            low_reg   <= CW'(SLOTS);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                count_reg <= count_next;
                low_reg   <= low_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            idx_reg <= slot_index;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign slots_in_use = count_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("in-use count beyond pool size");
    a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= height)
        else $error("low-water mark above stack height");
    a_push_above_low: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> height >= low_reg)
        else $error("push below low-water mark");
    a_grant_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_DONE) |-> granted_slot == '0)
        else $error("slot granted on failed request");
`endif

endmodule

@@ design/slot_free_list_allocator_unit.sv @@
// slot free-list allocator: lifo pool of slots with used marks and in-use count
// the result strobe done is registered from the execute state that follows the accept edge of a request
// a new request is not accepted while busy, so each request completes before the next one is taken
// busy is high for the one cycle between accept and result; done lasts one cycle
// reset (rst_n low, asynchronous) empties the pool use and marks; no clearing pass,
// unpopped positions read as their own index, ungranted slots as unused, via a low-water mark
module slot_free_list_allocator_unit #(
    parameter int SLOTS = sfla_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       operation,
    input  logic [$clog2(SLOTS)-1:0]   slot_index,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [$clog2(SLOTS)-1:0]   granted_slot,
    output logic [$clog2(SLOTS+1)-1:0] slots_in_use
);

    import sfla_pkg::*;

    cmd_t cmd;

    sfla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    sfla_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .slot_index   (slot_index),
        .done         (done),
        .status       (status),
        .granted_slot (granted_slot),
        .slots_in_use (slots_in_use)
    );

endmodule
